// ===== hw/rtl/ibt_pkg.sv =====
// Shared types, constants and codes for the IoU box tracker.
package ibt_pkg;

    localparam int COORD_BITS = 12;
    localparam int HIST       = 3;
    localparam int PW    = COORD_BITS;       // position
    localparam int SW    = COORD_BITS + 1;   // size
    localparam int EW    = COORD_BITS + 2;   // right/bottom edge and extents
    localparam int AW    = 2 * EW;           // areas
    localparam int PRW   = 2 * AW;           // full multiplier product
    localparam int SUMW  = EW + 4;           // tenths-weighted corner sums
    localparam int QW    = EW + 1;           // sum / 10
    localparam int DIV_S = SUMW + 4;
    localparam logic [AW-1:0] DIV_R = AW'(((64'd1 << DIV_S) + 64'd9) / 64'd10);
    localparam int CFGW   = 25;
    localparam int MILLIW = 10;
    localparam logic [MILLIW-1:0] IOU_SCALE = MILLIW'(1000);
    localparam int ADDRW = 5;
    localparam int DATAW = 32;
    localparam logic [1:0] FRAMES_WARM = 2'(HIST);

    localparam logic [2:0] REG_FRAME_AREA  = 3'd0;
    localparam logic [2:0] REG_MIN_AREA    = 3'd1;
    localparam logic [2:0] REG_WARMUP_AREA = 3'd2;
    localparam logic [2:0] REG_AREA_LIMIT  = 3'd3;
    localparam logic [2:0] REG_FOUR_MILLI  = 3'd4;
    localparam logic [2:0] REG_TWO_MILLI   = 3'd5;

    localparam logic [2:0] CH_WARM   = 3'd0;
    localparam logic [2:0] CH_KEEP   = 3'd1;
    localparam logic [2:0] CH_BLEND4 = 3'd2;
    localparam logic [2:0] CH_HIST   = 3'd3;
    localparam logic [2:0] CH_NONE   = 3'd4;

    typedef struct packed {
        logic          box_present;
        logic [PW-1:0] box_left;
        logic [PW-1:0] box_top;
        logic [SW-1:0] box_width;
        logic [SW-1:0] box_height;
        logic          end_of_frame;
    } in_t;

    typedef struct packed {
        logic [PW-1:0] sel_left;
        logic [PW-1:0] sel_top;
        logic [SW-1:0] sel_width;
        logic [SW-1:0] sel_height;
        logic [2:0]    choice;
        logic          sel_valid;
    } out_t;

    typedef struct packed {
        logic [PW-1:0] l;
        logic [PW-1:0] t;
        logic [SW-1:0] w;
        logic [SW-1:0] h;
    } box_t;

    typedef struct packed {
        logic [CFGW-1:0]   frame_area;
        logic [CFGW-1:0]   min_box_area;
        logic [CFGW-1:0]   warmup_box_area;
        logic [CFGW-1:0]   area_change_limit;
        logic [MILLIW-1:0] four_box_iou_milli;
        logic [MILLIW-1:0] two_box_iou_milli;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CAREA, OP_WARM_UPD, OP_EXT_PC, OP_MUL_I, OP_MUL_U,
        OP_CMP_A, OP_CMP_B, OP_BEST_UPD, OP_WARM_OUT, OP_ACT, OP_PA, OP_AA,
        OP_EXT4, OP_EXT_PA, OP_T_A, OP_T_B, OP_PASS, OP_BLEND, OP_DIV, OP_FINAL
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CAREA, S_CFILT, S_PEXT, S_PI, S_PU, S_PXA, S_PXB, S_PUPD,
        S_EOF, S_WOUT, S_ACT, S_PA, S_AA, S_E4, S_I4, S_U4, S_T4A, S_T4B,
        S_PS4, S_E2, S_I2, S_U2, S_T2A, S_T2B, S_PS2, S_BLEND, S_DIV, S_FIN
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       sel4;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic cand_ok;
        logic warm_phase;
        logic eof;
        logic out_busy;
    } status_t;

endpackage

// ===== hw/rtl/ibt_regs.sv =====
// Configuration register file with APB-style access.
module ibt_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibt_pkg::ADDRW-1:0]  paddr,
    input  logic [ibt_pkg::DATAW-1:0]  pwdata,
    output logic [ibt_pkg::DATAW-1:0]  prdata,
    output logic                       pready,
    output ibt_pkg::cfg_t              cfg
);
    import ibt_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] ridx;
    logic       wr_en;

    assign pready = 1'b1;
    assign ridx   = paddr[ADDRW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_area         <= CFGW'(307200);
            cfg_reg.min_box_area       <= CFGW'(1000);
            cfg_reg.warmup_box_area    <= CFGW'(3000);
            cfg_reg.area_change_limit  <= CFGW'(20000);
            cfg_reg.four_box_iou_milli <= MILLIW'(300);
            cfg_reg.two_box_iou_milli  <= MILLIW'(430);
        end else if (wr_en) begin
            unique case (ridx)
                REG_FRAME_AREA:  cfg_reg.frame_area         <= pwdata[CFGW-1:0];
                REG_MIN_AREA:    cfg_reg.min_box_area       <= pwdata[CFGW-1:0];
                REG_WARMUP_AREA: cfg_reg.warmup_box_area    <= pwdata[CFGW-1:0];
                REG_AREA_LIMIT:  cfg_reg.area_change_limit  <= pwdata[CFGW-1:0];
                REG_FOUR_MILLI:  cfg_reg.four_box_iou_milli <= pwdata[MILLIW-1:0];
                REG_TWO_MILLI:   cfg_reg.two_box_iou_milli  <= pwdata[MILLIW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_FRAME_AREA:  prdata = DATAW'(cfg_reg.frame_area);
            REG_MIN_AREA:    prdata = DATAW'(cfg_reg.min_box_area);
            REG_WARMUP_AREA: prdata = DATAW'(cfg_reg.warmup_box_area);
            REG_AREA_LIMIT:  prdata = DATAW'(cfg_reg.area_change_limit);
            REG_FOUR_MILLI:  prdata = DATAW'(cfg_reg.four_box_iou_milli);
            REG_TWO_MILLI:   prdata = DATAW'(cfg_reg.two_box_iou_milli);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/ibt_ctrl.sv =====
// Sequencer that steps the datapath through candidate and frame-end work.
module ibt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ibt_pkg::status_t  status,
    output ibt_pkg::cmd_t     cmd
);
    import ibt_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= 2'd0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.sel4     = 1'b0;
        cmd.idx      = div_cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CAREA;
                end
            end
            S_CAREA: begin
                cmd.op     = OP_CAREA;
                state_next = S_CFILT;
            end
            S_CFILT: begin
                cmd.op     = OP_WARM_UPD;
                state_next = (status.cand_ok && !status.warm_phase) ? S_PEXT : S_EOF;
            end
            S_PEXT: begin cmd.op = OP_EXT_PC;   state_next = S_PI;   end
            S_PI:   begin cmd.op = OP_MUL_I;    state_next = S_PU;   end
            S_PU:   begin cmd.op = OP_MUL_U;    state_next = S_PXA;  end
            S_PXA:  begin cmd.op = OP_CMP_A;    state_next = S_PXB;  end
            S_PXB:  begin cmd.op = OP_CMP_B;    state_next = S_PUPD; end
            S_PUPD: begin cmd.op = OP_BEST_UPD; state_next = S_EOF;  end
            S_EOF: begin
                priority if (!status.eof) state_next = S_IDLE;
                else if (status.warm_phase) state_next = S_WOUT;
                else state_next = S_ACT;
            end
            S_WOUT: begin
                if (!status.out_busy) begin
                    cmd.op     = OP_WARM_OUT;
                    state_next = S_IDLE;
                end
            end
            S_ACT:  begin cmd.op = OP_ACT;    state_next = S_PA;  end
            S_PA:   begin cmd.op = OP_PA;     state_next = S_AA;  end
            S_AA:   begin cmd.op = OP_AA;     state_next = S_E4;  end
            S_E4:   begin cmd.op = OP_EXT4;   state_next = S_I4;  end
            S_I4:   begin cmd.op = OP_MUL_I;  state_next = S_U4;  end
            S_U4:   begin cmd.op = OP_MUL_U;  state_next = S_T4A; end
            S_T4A:  begin cmd.op = OP_T_A;    state_next = S_T4B; end
            S_T4B: begin
                cmd.op     = OP_T_B;
                cmd.sel4   = 1'b1;
                state_next = S_PS4;
            end
            S_PS4:  begin cmd.op = OP_PASS;   state_next = S_E2;  end
            S_E2:   begin cmd.op = OP_EXT_PA; state_next = S_I2;  end
            S_I2:   begin cmd.op = OP_MUL_I;  state_next = S_U2;  end
            S_U2:   begin cmd.op = OP_MUL_U;  state_next = S_T2A; end
            S_T2A:  begin cmd.op = OP_T_A;    state_next = S_T2B; end
            S_T2B:  begin cmd.op = OP_T_B;    state_next = S_PS2; end
            S_PS2:  begin cmd.op = OP_PASS;   state_next = S_BLEND; end
            S_BLEND: begin
                cmd.op       = OP_BLEND;
                div_cnt_next = 2'd0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 2'd1;
                if (div_cnt_reg == 2'd3) state_next = S_FIN;
            end
            S_FIN: begin
                if (!status.out_busy) begin
                    cmd.op     = OP_FINAL;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FINAL || cmd.op == OP_WARM_OUT) |-> !status.out_busy)
        else $error("result loaded over a pending beat");
    a_mid_frame_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EOF && !status.eof) |=> state_reg == S_IDLE)
        else $error("mid-frame item did not return to idle");
    a_div_four: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && $past(state_reg) == S_DIV) |-> $past(div_cnt_reg) == 2'd3)
        else $error("divide sequence cut short");

endmodule

// ===== hw/rtl/ibt_dp.sv =====
// Datapath: candidate and history registers, shared multiplier, output register.
module ibt_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  ibt_pkg::cmd_t     cmd,
    output ibt_pkg::status_t  status,
    input  ibt_pkg::in_t      s_data,
    input  ibt_pkg::cfg_t     cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output ibt_pkg::out_t     m_data
);
    import ibt_pkg::*;

    // state
    box_t            hist_reg [HIST];
    logic [1:0]      frames_reg;
    box_t            best_reg;
    logic [AW-1:0]   best_inter_reg, best_union_reg;
    logic            best_found_reg;
    box_t            warm_reg;
    logic            warm_found_reg;
    logic            m_valid_reg;
    // working registers
    box_t            cand_reg, act_reg;
    logic            present_reg, eof_reg;
    logic [AW-1:0]   carea_reg, pa_reg, aa_reg, inter_reg, union_reg;
    logic [EW-1:0]   ix_reg, iy_reg, ux_reg, uy_reg;
    logic            izero_reg, uzero_reg, pass_reg, blend4_reg;
    logic [PRW-1:0]  prod_a_reg, prod_b_reg;
    logic [SUMW-1:0] sum_reg [4];
    logic [QW-1:0]   q_reg [4];
    out_t            out_reg;

    logic [AW-1:0]   mul_a, mul_b, nu_eff, diff;
    logic [PRW-1:0]  mul_p;
    logic [MILLIW-1:0] milli_sel;
    logic            cand_ok, warm_phase, keep;
    box_t            prev, blend_box, sel_box;
    logic [SUMW-1:0] sum_next [4];

    // extent search
    box_t            bx [4];
    logic [3:0]      use_b;
    logic [EW-1:0]   ex_ix, ex_iy, ex_ux, ex_uy;
    logic            ex_izero, ex_uzero;

    assign prev       = hist_reg[HIST-1];
    assign warm_phase = (frames_reg != FRAMES_WARM);
    assign cand_ok    = present_reg && (carea_reg != AW'(cfg.frame_area))
                        && (carea_reg >= AW'(cfg.min_box_area));
    assign nu_eff     = (union_reg == '0) ? AW'(1) : union_reg;
    assign milli_sel  = cmd.sel4 ? cfg.four_box_iou_milli : cfg.two_box_iou_milli;
    assign diff       = (pa_reg > aa_reg) ? (pa_reg - aa_reg) : (aa_reg - pa_reg);
    assign keep       = pass_reg && (diff < AW'(cfg.area_change_limit));

    assign status.cand_ok    = cand_ok;
    assign status.warm_phase = warm_phase;
    assign status.eof        = eof_reg;
    assign status.out_busy   = m_valid_reg;
    assign m_valid           = m_valid_reg;
    assign m_data            = out_reg;

    always_comb begin
        bx[0] = act_reg;
        bx[1] = prev;
        bx[2] = hist_reg[0];
        bx[3] = hist_reg[1];
        use_b = 4'b0011;
        unique case (cmd.op)
            OP_EXT_PC: bx[0] = cand_reg;
            OP_EXT4: begin
                bx[1] = hist_reg[0];
                bx[2] = hist_reg[1];
                bx[3] = hist_reg[2];
                use_b = 4'b1111;
            end
            default: ;
        endcase
    end

    always_comb begin
        logic [EW-1:0] r_e, d_e, ix1, iy1, ix2, iy2, ux1, uy1, ux2, uy2;
        logic          seen, any_empty, any_u, empty;
        ix1 = '0; iy1 = '0; ix2 = '0; iy2 = '0;
        ux1 = '0; uy1 = '0; ux2 = '0; uy2 = '0;
        seen = 1'b0; any_empty = 1'b0; any_u = 1'b0;
        for (int i = 0; i < 4; i++) begin
            r_e   = EW'(bx[i].l) + EW'(bx[i].w);
            d_e   = EW'(bx[i].t) + EW'(bx[i].h);
            empty = (bx[i].w == '0) || (bx[i].h == '0);
            if (use_b[i]) begin
                if (empty) any_empty = 1'b1;
                if (!seen || EW'(bx[i].l) > ix1) ix1 = EW'(bx[i].l);
                if (!seen || EW'(bx[i].t) > iy1) iy1 = EW'(bx[i].t);
                if (!seen || r_e < ix2) ix2 = r_e;
                if (!seen || d_e < iy2) iy2 = d_e;
                seen = 1'b1;
                if (!empty) begin
                    if (!any_u || EW'(bx[i].l) < ux1) ux1 = EW'(bx[i].l);
                    if (!any_u || EW'(bx[i].t) < uy1) uy1 = EW'(bx[i].t);
                    if (!any_u || r_e > ux2) ux2 = r_e;
                    if (!any_u || d_e > uy2) uy2 = d_e;
                    any_u = 1'b1;
                end
            end
        end
        ex_izero = any_empty || (ix2 <= ix1) || (iy2 <= iy1);
        ex_uzero = !any_u;
        ex_ix    = ix2 - ix1;
        ex_iy    = iy2 - iy1;
        ex_ux    = ux2 - ux1;
        ex_uy    = uy2 - uy1;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_CAREA: begin mul_a = AW'(cand_reg.w); mul_b = AW'(cand_reg.h); end
            OP_MUL_I: begin mul_a = AW'(ix_reg);     mul_b = AW'(iy_reg);     end
            OP_MUL_U: begin mul_a = AW'(ux_reg);     mul_b = AW'(uy_reg);     end
            OP_CMP_A: begin mul_a = inter_reg;       mul_b = best_union_reg;  end
            OP_CMP_B: begin mul_a = best_inter_reg;  mul_b = nu_eff;          end
            OP_T_A:   begin mul_a = inter_reg;       mul_b = AW'(IOU_SCALE);  end
            OP_T_B:   begin mul_a = AW'(milli_sel);  mul_b = union_reg;       end
            OP_PA:    begin mul_a = AW'(prev.w);     mul_b = AW'(prev.h);     end
            OP_AA:    begin mul_a = AW'(act_reg.w);  mul_b = AW'(act_reg.h);  end
            OP_DIV:   begin mul_a = AW'(sum_reg[cmd.idx]); mul_b = DIV_R;     end
            default: ;
        endcase
    end
    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    // corner sums, tenths weights
    always_comb begin
        logic [SUMW-1:0] a0, a1, a2, a3;
        for (int k = 0; k < 4; k++) begin
            unique case (k)
                0: begin
                    a0 = SUMW'(hist_reg[0].l); a1 = SUMW'(hist_reg[1].l);
                    a2 = SUMW'(hist_reg[2].l); a3 = SUMW'(act_reg.l);
                end
                1: begin
                    a0 = SUMW'(hist_reg[0].t); a1 = SUMW'(hist_reg[1].t);
                    a2 = SUMW'(hist_reg[2].t); a3 = SUMW'(act_reg.t);
                end
                2: begin
                    a0 = SUMW'(hist_reg[0].l) + SUMW'(hist_reg[0].w);
                    a1 = SUMW'(hist_reg[1].l) + SUMW'(hist_reg[1].w);
                    a2 = SUMW'(hist_reg[2].l) + SUMW'(hist_reg[2].w);
                    a3 = SUMW'(act_reg.l) + SUMW'(act_reg.w);
                end
                default: begin
                    a0 = SUMW'(hist_reg[0].t) + SUMW'(hist_reg[0].h);
                    a1 = SUMW'(hist_reg[1].t) + SUMW'(hist_reg[1].h);
                    a2 = SUMW'(hist_reg[2].t) + SUMW'(hist_reg[2].h);
                    a3 = SUMW'(act_reg.t) + SUMW'(act_reg.h);
                end
            endcase
            if (pa_reg > aa_reg)
                sum_next[k] = a0 + (a1 << 1) + a1 + (a2 << 2) + a2 + a3;
            else
                sum_next[k] = (a0 << 1) + (a1 << 1) + (a2 << 2) + (a2 << 1);
        end
    end

    always_comb begin
        blend_box.l = PW'(q_reg[0]);
        blend_box.t = PW'(q_reg[1]);
        blend_box.w = SW'(q_reg[2] - q_reg[0]);
        blend_box.h = SW'(q_reg[3] - q_reg[1]);
        sel_box     = keep ? act_reg : blend_box;
    end

    // tracker state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST; i++) hist_reg[i] <= '0;
            frames_reg     <= 2'd0;
            best_reg       <= '0;
            best_inter_reg <= '0;
            best_union_reg <= '0;
            best_found_reg <= 1'b0;
            warm_reg       <= '0;
            warm_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (cmd.op)
                OP_WARM_UPD: begin
                    if (cand_ok && warm_phase && carea_reg >= AW'(cfg.warmup_box_area)) begin
                        warm_reg       <= cand_reg;
                        warm_found_reg <= 1'b1;
                    end
                end
                OP_BEST_UPD: begin
                    if (!best_found_reg || prod_a_reg > prod_b_reg) begin
                        best_reg       <= cand_reg;
                        best_inter_reg <= inter_reg;
                        best_union_reg <= nu_eff;
                        best_found_reg <= 1'b1;
                    end
                end
                OP_WARM_OUT: begin
                    if (warm_found_reg) begin
                        hist_reg[0] <= hist_reg[1];
                        hist_reg[1] <= hist_reg[2];
                        hist_reg[2] <= warm_reg;
                        frames_reg  <= frames_reg + 2'd1;
                    end
                    m_valid_reg    <= 1'b1;
                    best_found_reg <= 1'b0;
                    warm_found_reg <= 1'b0;
                    best_inter_reg <= '0;
                    best_union_reg <= '0;
                end
                OP_FINAL: begin
                    hist_reg[0]    <= hist_reg[1];
                    hist_reg[1]    <= hist_reg[2];
                    hist_reg[2]    <= sel_box;
                    m_valid_reg    <= 1'b1;
                    best_found_reg <= 1'b0;
                    warm_found_reg <= 1'b0;
                    best_inter_reg <= '0;
                    best_union_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                cand_reg.l  <= s_data.box_left;
                cand_reg.t  <= s_data.box_top;
                cand_reg.w  <= s_data.box_width;
                cand_reg.h  <= s_data.box_height;
                present_reg <= s_data.box_present;
                eof_reg     <= s_data.end_of_frame;
            end
            OP_CAREA: carea_reg <= mul_p[AW-1:0];
            OP_EXT_PC, OP_EXT_PA, OP_EXT4: begin
                ix_reg    <= ex_ix;
                iy_reg    <= ex_iy;
                ux_reg    <= ex_ux;
                uy_reg    <= ex_uy;
                izero_reg <= ex_izero;
                uzero_reg <= ex_uzero;
            end
            OP_MUL_I: inter_reg <= izero_reg ? '0 : mul_p[AW-1:0];
            OP_MUL_U: union_reg <= uzero_reg ? '0 : mul_p[AW-1:0];
            OP_CMP_A, OP_T_A: prod_a_reg <= mul_p;
            OP_CMP_B, OP_T_B: prod_b_reg <= mul_p;
            OP_ACT: begin
                act_reg  <= best_found_reg ? best_reg : prev;
                pass_reg <= 1'b0;
            end
            OP_PA: pa_reg <= mul_p[AW-1:0];
            OP_AA: aa_reg <= mul_p[AW-1:0];
            OP_PASS: begin
                if (union_reg != '0 && prod_a_reg >= prod_b_reg) pass_reg <= 1'b1;
            end
            OP_BLEND: begin
                blend4_reg <= (pa_reg > aa_reg);
                for (int k = 0; k < 4; k++) sum_reg[k] <= sum_next[k];
            end
            OP_DIV: q_reg[cmd.idx] <= QW'(mul_p >> DIV_S);
            OP_WARM_OUT: begin
                if (warm_found_reg) begin
                    out_reg.sel_left   <= warm_reg.l;
                    out_reg.sel_top    <= warm_reg.t;
                    out_reg.sel_width  <= warm_reg.w;
                    out_reg.sel_height <= warm_reg.h;
                    out_reg.choice     <= CH_WARM;
                    out_reg.sel_valid  <= 1'b1;
                end else begin
                    out_reg.sel_left   <= '0;
                    out_reg.sel_top    <= '0;
                    out_reg.sel_width  <= '0;
                    out_reg.sel_height <= '0;
                    out_reg.choice     <= CH_NONE;
                    out_reg.sel_valid  <= 1'b0;
                end
            end
            OP_FINAL: begin
                out_reg.sel_left   <= sel_box.l;
                out_reg.sel_top    <= sel_box.t;
                out_reg.sel_width  <= sel_box.w;
                out_reg.sel_height <= sel_box.h;
                out_reg.choice     <= keep ? CH_KEEP : (blend4_reg ? CH_BLEND4 : CH_HIST);
                out_reg.sel_valid  <= 1'b1;
            end
            default: ;
        endcase
    end

    a_best_after_warmup: assert property (@(posedge aclk) disable iff (!aresetn)
        best_found_reg |-> (frames_reg == FRAMES_WARM))
        else $error("best candidate tracked during warm-up");
    a_warmup_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (frames_reg == FRAMES_WARM) |=> (frames_reg == FRAMES_WARM))
        else $error("frame count left tracking phase");
    a_final_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FINAL || cmd.op == OP_WARM_OUT) |=> m_valid_reg)
        else $error("frame result beat not raised");

endmodule

// ===== hw/rtl/iou_box_tracker_step.sv =====
// Top level of the IoU box tracker: registers, sequencer and datapath.
// Mid-frame item: load, area and filter; a ranked item adds extents, products and best update.
// End-of-frame item: warm-up output, or ratio tests, blend and divide, plus any wait for a pending
// result beat; one shared multiplier takes one product per cycle; result sits in an output reg.
// Items are taken one at a time; a new one is accepted while a result beat still waits.
// Reset (aresetn low, synchronous): registers to defaults, history and frame count to zero.
module iou_box_tracker_step (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ibt_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ibt_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibt_pkg::ADDRW-1:0]  paddr,
    input  logic [ibt_pkg::DATAW-1:0]  pwdata,
    output logic [ibt_pkg::DATAW-1:0]  prdata,
    output logic                       pready
);
    import ibt_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    ibt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ibt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ibt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .cfg     (cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the IoU box tracker: directed and random frames checked against a local predictor.
`timescale 1ns / 1ps
module tb_top;
    import ibt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDRW-1:0] paddr = '0;
    logic [DATAW-1:0] pwdata = '0;
    logic [DATAW-1:0] prdata;
    logic pready;

    iou_box_tracker_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // tracker shadow state
    longint unsigned frame_area_q, min_area_q, warm_area_q, area_lim_q, four_milli_q, two_milli_q;
    box_t   hist_q [HIST];
    int     frames_q;
    box_t   best_q, warm_q;
    longint unsigned best_inter_q, best_union_q;
    bit     best_found_q, warm_found_q;

    out_t   sel_expected [$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;
    bit     long_stall = 1'b0;

    function automatic longint unsigned box_area(box_t b);
        return longint'(b.w) * longint'(b.h);
    endfunction

    function automatic longint unsigned overlap_area(box_t b [], int n);
        longint unsigned x1, y1, x2, y2, r, d;
        x1 = 0; y1 = 0; x2 = 0; y2 = 0;
        for (int i = 0; i < n; i++) begin
            if (b[i].w == 0 || b[i].h == 0) return 0;
            r = b[i].l + b[i].w;
            d = b[i].t + b[i].h;
            if (i == 0 || b[i].l > x1) x1 = b[i].l;
            if (i == 0 || b[i].t > y1) y1 = b[i].t;
            if (i == 0 || r < x2) x2 = r;
            if (i == 0 || d < y2) y2 = d;
        end
        if (x2 <= x1 || y2 <= y1) return 0;
        return (x2 - x1) * (y2 - y1);
    endfunction

    function automatic longint unsigned hull_area(box_t b [], int n);
        longint unsigned x1, y1, x2, y2, r, d;
        bit any;
        x1 = 0; y1 = 0; x2 = 0; y2 = 0; any = 0;
        for (int i = 0; i < n; i++) begin
            if (b[i].w == 0 || b[i].h == 0) continue;
            r = b[i].l + b[i].w;
            d = b[i].t + b[i].h;
            if (!any || b[i].l < x1) x1 = b[i].l;
            if (!any || b[i].t < y1) y1 = b[i].t;
            if (!any || r > x2) x2 = r;
            if (!any || d > y2) y2 = d;
            any = 1;
        end
        if (!any) return 0;
        return (x2 - x1) * (y2 - y1);
    endfunction

    function automatic bit ratio_passes(longint unsigned in_a, longint unsigned un_a,
                                        longint unsigned milli);
        return un_a != 0 && in_a * 1000 >= milli * un_a;
    endfunction

    function automatic void push_hist(box_t b);
        hist_q[0] = hist_q[1];
        hist_q[1] = hist_q[2];
        hist_q[2] = b;
    endfunction

    function automatic void reset_tracker();
        frame_area_q = 307200; min_area_q = 1000; warm_area_q = 3000;
        area_lim_q = 20000; four_milli_q = 300; two_milli_q = 430;
        foreach (hist_q[i]) hist_q[i] = '0;
        frames_q = 0;
        best_q = '0; warm_q = '0; best_inter_q = 0; best_union_q = 0;
        best_found_q = 0; warm_found_q = 0;
    endfunction

    function automatic void track_item(in_t it);
        box_t c, prev, act, sel;
        box_t pr [] = new[2];
        box_t all [] = new[4];
        longint unsigned a, ni, nu, pa, aa, diff, x1, y1, x2, y2;
        bit p4, p2;
        out_t res;
        c = '{it.box_left, it.box_top, it.box_width, it.box_height};
        if (it.box_present) begin
            a = box_area(c);
            if (a != frame_area_q && a >= min_area_q) begin
                if (frames_q < HIST) begin
                    if (a >= warm_area_q) begin
                        warm_q = c; warm_found_q = 1;
                    end
                end else begin
                    pr[0] = c; pr[1] = hist_q[2];
                    ni = overlap_area(pr, 2); nu = hull_area(pr, 2);
                    if (nu == 0) begin
                        ni = 0; nu = 1;
                    end
                    if (!best_found_q || ni * best_union_q > best_inter_q * nu) begin
                        best_q = c; best_inter_q = ni; best_union_q = nu; best_found_q = 1;
                    end
                end
            end
        end
        if (!it.end_of_frame) return;
        sel = '0;
        res = '0;
        res.choice = CH_NONE;
        if (frames_q < HIST) begin
            if (warm_found_q) begin
                sel = warm_q; res.choice = CH_WARM; res.sel_valid = 1;
                push_hist(sel);
                frames_q++;
            end
        end else begin
            prev = hist_q[2];
            act = best_found_q ? best_q : prev;
            pa = box_area(prev); aa = box_area(act);
            diff = pa > aa ? pa - aa : aa - pa;
            all[0] = act; all[1] = hist_q[0]; all[2] = hist_q[1]; all[3] = hist_q[2];
            p4 = ratio_passes(overlap_area(all, 4), hull_area(all, 4), four_milli_q);
            pr[0] = act; pr[1] = prev;
            p2 = ratio_passes(overlap_area(pr, 2), hull_area(pr, 2), two_milli_q);
            if ((p4 || p2) && diff < area_lim_q) begin
                sel = act; res.choice = CH_KEEP;
            end else begin
                if (pa > aa) begin
                    x1 = hist_q[0].l + 3*hist_q[1].l + 5*hist_q[2].l + act.l;
                    y1 = hist_q[0].t + 3*hist_q[1].t + 5*hist_q[2].t + act.t;
                    x2 = (hist_q[0].l + hist_q[0].w) + 3*(hist_q[1].l + hist_q[1].w)
                       + 5*(hist_q[2].l + hist_q[2].w) + (act.l + act.w);
                    y2 = (hist_q[0].t + hist_q[0].h) + 3*(hist_q[1].t + hist_q[1].h)
                       + 5*(hist_q[2].t + hist_q[2].h) + (act.t + act.h);
                    res.choice = CH_BLEND4;
                end else begin
                    x1 = 2*hist_q[0].l + 2*hist_q[1].l + 6*hist_q[2].l;
                    y1 = 2*hist_q[0].t + 2*hist_q[1].t + 6*hist_q[2].t;
                    x2 = 2*(hist_q[0].l + hist_q[0].w) + 2*(hist_q[1].l + hist_q[1].w)
                       + 6*(hist_q[2].l + hist_q[2].w);
                    y2 = 2*(hist_q[0].t + hist_q[0].h) + 2*(hist_q[1].t + hist_q[1].h)
                       + 6*(hist_q[2].t + hist_q[2].h);
                    res.choice = CH_HIST;
                end
                x1 /= 10; y1 /= 10; x2 /= 10; y2 /= 10;
                sel.l = x1[PW-1:0];
                sel.t = y1[PW-1:0];
                sel.w = SW'(x2 >= x1 ? x2 - x1 : x1 - x2);
                sel.h = SW'(y2 >= y1 ? y2 - y1 : y1 - y2);
            end
            res.sel_valid = 1;
            push_hist(sel);
        end
        res.sel_left = sel.l; res.sel_top = sel.t;
        res.sel_width = sel.w; res.sel_height = sel.h;
        sel_expected = {sel_expected, res};
        best_q = '0; warm_q = '0; best_inter_q = 0; best_union_q = 0;
        best_found_q = 0; warm_found_q = 0;
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sel_expected.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                want = sel_expected.pop_front();
                if (m_data.sel_left !== want.sel_left)
                    $display("%0t: sel_left exp %0d got %0d", $time, want.sel_left, m_data.sel_left);
                if (m_data.sel_top !== want.sel_top)
                    $display("%0t: sel_top exp %0d got %0d", $time, want.sel_top, m_data.sel_top);
                if (m_data.sel_width !== want.sel_width)
                    $display("%0t: sel_width exp %0d got %0d", $time, want.sel_width,
                             m_data.sel_width);
                if (m_data.sel_height !== want.sel_height)
                    $display("%0t: sel_height exp %0d got %0d", $time, want.sel_height,
                             m_data.sel_height);
                if (m_data.choice !== want.choice)
                    $display("%0t: choice exp %0d got %0d", $time, want.choice, m_data.choice);
                if (m_data.sel_valid !== want.sel_valid)
                    $display("%0t: sel_valid exp %0d got %0d", $time, want.sel_valid,
                             m_data.sel_valid);
                if (m_data !== want) errors++;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    always @(negedge aclk) begin
        int r;
        r = $urandom_range(0, 15);
        if (long_stall) m_ready <= 1'b0;
        else m_ready <= (r < 11) || (($time / 4000) % 3 == 0);
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(in_t it);
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_item(it);
        @(negedge aclk);
    endtask

    task automatic idle_input();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (sel_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint unsigned val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDRW'(4 * idx); pwdata <= DATAW'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FRAME_AREA:  frame_area_q = val & 25'h1ffffff;
            REG_MIN_AREA:    min_area_q   = val & 25'h1ffffff;
            REG_WARMUP_AREA: warm_area_q  = val & 25'h1ffffff;
            REG_AREA_LIMIT:  area_lim_q   = val & 25'h1ffffff;
            REG_FOUR_MILLI:  four_milli_q = val & 10'h3ff;
            REG_TWO_MILLI:   two_milli_q  = val & 10'h3ff;
            default: ;
        endcase
    endtask

    task automatic set_config(longint unsigned fa, longint unsigned mn, longint unsigned wu,
                              longint unsigned lim, longint unsigned f4, longint unsigned t2);
        write_reg(REG_FRAME_AREA, fa);
        write_reg(REG_MIN_AREA, mn);
        write_reg(REG_WARMUP_AREA, wu);
        write_reg(REG_AREA_LIMIT, lim);
        write_reg(REG_FOUR_MILLI, f4);
        write_reg(REG_TWO_MILLI, t2);
    endtask

    function automatic in_t mk(bit p, int l, int t, int w, int h, bit eof);
        in_t it;
        it.box_present = p; it.box_left = PW'(l); it.box_top = PW'(t);
        it.box_width = SW'(w); it.box_height = SW'(h); it.end_of_frame = eof;
        return it;
    endfunction

    // candidate jittered around the newest tracked box so that ranking stays interesting
    function automatic in_t near_box(bit eof);
        box_t b;
        int l, t, w, h;
        b = hist_q[2];
        l = int'(b.l) + $signed($urandom_range(0, 40)) - 20;
        t = int'(b.t) + $signed($urandom_range(0, 40)) - 20;
        w = int'(b.w) + $signed($urandom_range(0, 40)) - 20;
        h = int'(b.h) + $signed($urandom_range(0, 40)) - 20;
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (w < 1) w = $urandom_range(40, 200);
        if (h < 1) h = $urandom_range(40, 200);
        return mk(1, l, t, w, h, eof);
    endfunction

    function automatic in_t rand_box(bit eof);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return mk($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4096), $urandom_range(0, 4096), eof);
        if (sel < 3)
            return mk($urandom_range(0, 1), $urandom_range(0, 600), $urandom_range(0, 450),
                      $urandom_range(0, 300), $urandom_range(0, 300), eof);
        return near_box(eof);
    endfunction

    task automatic run_frame(int n_cand);
        for (int i = 0; i < n_cand; i++) send_beat(rand_box(1'b0));
        if ($urandom_range(0, 1)) send_beat(rand_box(1'b1));
        else send_beat(mk($urandom_range(0, 1) == 0 ? 1'b0 : 1'b0,
                          $urandom_range(0, 4095), 0, 0, 0, 1'b1));
    endtask

    task automatic test_warmup();
        // frame with nothing large enough is skipped
        send_beat(mk(1, 10, 10, 20, 20, 0));
        send_beat(mk(0, 4095, 4095, 4096, 4096, 1));
        // full-frame candidate is ignored, last warm candidate wins
        send_beat(mk(1, 0, 0, 640, 480, 0));
        send_beat(mk(1, 100, 100, 80, 60, 0));
        send_beat(mk(1, 110, 105, 90, 70, 1));
        send_beat(mk(1, 112, 108, 88, 72, 1));
        send_beat(mk(1, 4095, 4095, 4096, 4096, 1));
    endtask

    task automatic test_tracking();
        send_beat(mk(1, 114, 110, 90, 70, 0));
        send_beat(mk(1, 114, 110, 90, 70, 0));   // tie keeps the first
        send_beat(mk(1, 3000, 3000, 50, 50, 1));
        send_beat(mk(0, 0, 0, 0, 0, 1));         // no candidate: previous stands
        send_beat(mk(1, 0, 0, 4096, 4096, 1));   // huge: blend
        send_beat(mk(1, 1500, 1500, 40, 30, 1)); // small, far: blend
        send_beat(mk(1, 0, 0, 0, 4096, 1));      // empty box
        send_beat(mk(1, 4095, 0, 4096, 1, 1));
        wait_drained();
    endtask

    task automatic test_random(int n_frames);
        for (int f = 0; f < n_frames; f++) run_frame($urandom_range(0, 4));
        wait_drained();
    endtask

    task automatic test_back_pressure();
        fork
            begin
                long_stall = 1'b1;
                hold_off = 1'b1;
                repeat (600) @(negedge aclk);
                long_stall = 1'b0;
                hold_off = 1'b0;
            end
            begin
                for (int f = 0; f < 20; f++) run_frame(1);
            end
        join
        wait_drained();
    endtask

    initial begin
        reset_tracker();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_warmup();
        test_tracking();
        test_random(120);
        test_back_pressure();

        set_config(0, 0, 0, 0, 0, 0);
        test_random(60);
        set_config(25'h1ffffff, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff, 1023, 1023);
        test_random(20);
        set_config(40000, 500, 2000, 8000, 1000, 1000);
        test_random(60);
        set_config(307200, 1000, 3000, 16777216, 0, 1000);
        test_random(60);
        set_config(307200, 200, 3000, 20000, 300, 430);
        test_random(45);

        wait_drained();
        if (errors == 0 && sel_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
